// ----- rtl/core/mcacc_pkg.sv -----
// ----------------------------------------------------------------------------
// mcacc_pkg
// Shared types, constants and helpers for the 4x4 matrix compose accumulator.
// ----------------------------------------------------------------------------
package mcacc_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAT_N      = 16;
  localparam int IDX_W      = 4;
  localparam int STEP_W     = 6;
  localparam int PROD_W     = 2 * DATA_WIDTH - FRAC_BITS;
  localparam int ACC_W      = PROD_W + 2;

  localparam logic [DATA_WIDTH-1:0] Q_ONE = {{(DATA_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;
  localparam logic [DATA_WIDTH-1:0] Q_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] Q_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [IDX_W-1:0]      IDX_LAST = {IDX_W{1'b1}};

  localparam logic OP_ELEMENT  = 1'b0;
  localparam logic OP_IDENTITY = 1'b1;

  typedef struct packed {
    logic                         opcode;
    logic signed [DATA_WIDTH-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [IDX_W-1:0]             result_index;
    logic                         last_element;
  } result_t;

  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last;
    logic [IDX_W-1:0] index;
  } mac_tag_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_ISSUE,
    SEQ_DRAIN
  } seq_state_t;

  // Column-major index c*4+r lies on the diagonal when row equals column.
  function automatic logic [DATA_WIDTH-1:0] identity_value(input logic [IDX_W-1:0] idx);
    identity_value = (idx[1:0] == idx[3:2]) ? Q_ONE : '0;
  endfunction

endpackage

// ----- rtl/core/mcacc_incoming_ram.sv -----
// ----------------------------------------------------------------------------
// mcacc_incoming_ram
// Sixteen-entry store for the right-hand matrix, one write and one read port.
// ----------------------------------------------------------------------------
module mcacc_incoming_ram (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [mcacc_pkg::IDX_W-1:0]            wr_addr,
  input  logic [mcacc_pkg::DATA_WIDTH-1:0]       wr_data,
  input  logic                                   rd_en,
  input  logic [mcacc_pkg::IDX_W-1:0]            rd_addr,
  output logic [mcacc_pkg::DATA_WIDTH-1:0]       rd_data
);

  logic [mcacc_pkg::DATA_WIDTH-1:0] mem [mcacc_pkg::MAT_N];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/mcacc_stored_ram.sv -----
// ----------------------------------------------------------------------------
// mcacc_stored_ram
// Two-bank store for the accumulated matrix with per-entry valid bits.
// Reads come from the active bank, products are written to the other one.
// ----------------------------------------------------------------------------
module mcacc_stored_ram (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   clear,
  input  logic                                   flip,
  input  logic                                   rd_en,
  input  logic [mcacc_pkg::IDX_W-1:0]            rd_addr,
  output logic [mcacc_pkg::DATA_WIDTH-1:0]       rd_data,
  input  logic                                   wr_en,
  input  logic [mcacc_pkg::IDX_W-1:0]            wr_addr,
  input  logic [mcacc_pkg::DATA_WIDTH-1:0]       wr_data
);

  localparam int DEPTH = 2 * mcacc_pkg::MAT_N;

  logic [mcacc_pkg::DATA_WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0]                 valid;
  logic                             bank;
  logic [mcacc_pkg::DATA_WIDTH-1:0] rd_q;
  logic                             rd_valid_q;
  logic [mcacc_pkg::IDX_W-1:0]      rd_idx_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank  <= 1'b0;
      valid <= '0;
    end else begin
      if (clear) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[{~bank, wr_addr}] <= 1'b1;
      end
      if (flip) begin
        bank <= ~bank;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{~bank, wr_addr}] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q       <= mem[{bank, rd_addr}];
      rd_valid_q <= valid[{bank, rd_addr}];
      rd_idx_q   <= rd_addr;
    end
  end

  // An entry never written since the last identity load reads as identity.
  assign rd_data = rd_valid_q ? rd_q : mcacc_pkg::identity_value(rd_idx_q);

endmodule

// ----- rtl/core/mcacc_mac.sv -----
// ----------------------------------------------------------------------------
// mcacc_mac
// Shared multiply-accumulate: product, fractional shift, four-term sum and
// saturation to the stored word width.
// ----------------------------------------------------------------------------
module mcacc_mac (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   en,
  input  mcacc_pkg::mac_tag_t                    tag_in,
  input  logic [mcacc_pkg::DATA_WIDTH-1:0]       op_a,
  input  logic [mcacc_pkg::DATA_WIDTH-1:0]       op_b,
  output mcacc_pkg::mac_tag_t                    tag_out,
  output logic [mcacc_pkg::DATA_WIDTH-1:0]       sum_sat
);

  logic signed [2*mcacc_pkg::DATA_WIDTH-1:0] full_prod;
  logic signed [2*mcacc_pkg::DATA_WIDTH-1:0] shifted;
  logic signed [mcacc_pkg::PROD_W-1:0]       prod;
  logic signed [mcacc_pkg::ACC_W-1:0]        prod_ext;
  logic signed [mcacc_pkg::ACC_W-1:0]        acc;
  mcacc_pkg::mac_tag_t                       tag_prod;
  logic                                      in_range;

  assign full_prod = $signed(op_a) * $signed(op_b);
  assign shifted   = full_prod >>> mcacc_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= shifted[mcacc_pkg::PROD_W-1:0];
    end
  end

  assign prod_ext = {{(mcacc_pkg::ACC_W-mcacc_pkg::PROD_W){prod[mcacc_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (en) begin
      if (tag_prod.first) begin
        acc <= prod_ext;
      end else begin
        acc <= acc + prod_ext;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_prod <= '0;
      tag_out  <= '0;
    end else if (en) begin
      tag_prod <= tag_in;
      tag_out  <= tag_prod;
    end
  end

  // The sum fits when every bit above the sign position copies the sign.
  assign in_range = (acc[mcacc_pkg::ACC_W-1:mcacc_pkg::DATA_WIDTH-1] == '0) ||
                    (acc[mcacc_pkg::ACC_W-1:mcacc_pkg::DATA_WIDTH-1] == '1);

  always_comb begin
    if (in_range) begin
      sum_sat = acc[mcacc_pkg::DATA_WIDTH-1:0];
    end else if (acc[mcacc_pkg::ACC_W-1]) begin
      sum_sat = mcacc_pkg::Q_MIN;
    end else begin
      sum_sat = mcacc_pkg::Q_MAX;
    end
  end

endmodule

// ----- rtl/core/matrix4_compose_accumulator.sv -----
// ----------------------------------------------------------------------------
// matrix4_compose_accumulator
// Keeps a 4x4 column-major Q16.16 transform and composes it with right-hand
// matrices that arrive one element per beat.
// ----------------------------------------------------------------------------
// The block holds a stored matrix, identity after reset, and takes input beats
// that either reload identity or carry one element of a right-hand matrix in
// column-major order. Element beats are taken one per cycle while no product
// is in flight. The sixteenth element starts the product stored * incoming: 64
// multiply-accumulate steps through a single shared multiplier, one step per
// cycle unless the result channel stalls, and four steps for each result beat.
// The pace of a product is set by the one multiplier and the one read port of
// each matrix memory. Input is stalled from the sixteenth element until the
// last result has entered the output register; a stall on the result channel
// freezes the whole multiply pipeline. Each product is shifted right by the
// fraction width (floor), the four products of an element are summed exactly,
// and the sum saturates to 32 bits. The stored matrix sits in a two-bank
// memory so that new elements never overwrite values that later elements of
// the same product still read; an identity beat takes effect at once through
// per-entry valid bits, with no clearing pass.
// ----------------------------------------------------------------------------
module matrix4_compose_accumulator (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_stall,
  input  mcacc_pkg::item_t    item,
  output logic                result_valid,
  input  logic                result_stall,
  output mcacc_pkg::result_t  result
);

  mcacc_pkg::seq_state_t            state;
  mcacc_pkg::seq_state_t            state_next;
  logic [mcacc_pkg::IDX_W-1:0]      count;
  logic [mcacc_pkg::IDX_W-1:0]      count_next;
  logic [mcacc_pkg::STEP_W-1:0]     step;
  logic [mcacc_pkg::STEP_W-1:0]     step_next;

  logic                             item_take;
  logic                             elem_wr;
  logic                             ident_load;
  logic                             en;
  logic                             issue;
  mcacc_pkg::mac_tag_t              issue_tag;
  mcacc_pkg::mac_tag_t              tag_rd;
  mcacc_pkg::mac_tag_t              tag_done;
  logic                             load;
  logic                             load_last;

  logic [mcacc_pkg::IDX_W-1:0]      stored_addr;
  logic [mcacc_pkg::IDX_W-1:0]      incoming_addr;
  logic [mcacc_pkg::DATA_WIDTH-1:0] stored_data;
  logic [mcacc_pkg::DATA_WIDTH-1:0] incoming_data;
  logic [mcacc_pkg::DATA_WIDTH-1:0] sum_sat;

  // The step counter walks column, row and term: step = {c, r, k}.
  assign stored_addr   = {step[1:0], step[3:2]};
  assign incoming_addr = {step[5:4], step[1:0]};

  // Everything behind the memories advances unless a finished result is
  // still waiting in the output register.
  assign en = !(result_valid && result_stall);

  // Input beats are taken only while no product is in flight.
  assign item_stall = (state != mcacc_pkg::SEQ_IDLE);

  assign item_take  = item_valid && !item_stall;
  assign ident_load = item_take && (item.opcode == mcacc_pkg::OP_IDENTITY);
  assign elem_wr    = item_take && (item.opcode == mcacc_pkg::OP_ELEMENT);

  assign load      = en && tag_done.valid && tag_done.last;
  assign load_last = load && (tag_done.index == mcacc_pkg::IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcacc_pkg::SEQ_IDLE;
      count <= '0;
      step  <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    count_next = count;
    step_next  = step;
    issue      = 1'b0;
    unique case (state)
      mcacc_pkg::SEQ_IDLE: begin
        if (ident_load) begin
          count_next = '0;
        end else if (elem_wr) begin
          count_next = count + 1'b1;
          if (count == mcacc_pkg::IDX_LAST) begin
            step_next  = '0;
            state_next = mcacc_pkg::SEQ_ISSUE;
          end
        end
      end
      mcacc_pkg::SEQ_ISSUE: begin
        issue = en;
        if (en) begin
          step_next = step + 1'b1;
          if (step == {mcacc_pkg::STEP_W{1'b1}}) begin
            state_next = mcacc_pkg::SEQ_DRAIN;
          end
        end
      end
      mcacc_pkg::SEQ_DRAIN: begin
        if (load_last) begin
          state_next = mcacc_pkg::SEQ_IDLE;
        end
      end
      default: begin
        state_next = mcacc_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_comb begin
    issue_tag.valid = issue;
    issue_tag.first = (step[1:0] == 2'd0);
    issue_tag.last  = (step[1:0] == 2'd3);
    issue_tag.index = step[5:2];
  end

  // Tag travels alongside the registered memory read.
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd <= '0;
    end else if (en) begin
      tag_rd <= issue_tag;
    end
  end

  mcacc_incoming_ram u_incoming (
    .clk     (clk),
    .wr_en   (elem_wr),
    .wr_addr (count),
    .wr_data (item.element_value),
    .rd_en   (en),
    .rd_addr (incoming_addr),
    .rd_data (incoming_data)
  );

  mcacc_stored_ram u_stored (
    .clk     (clk),
    .rst     (rst),
    .clear   (ident_load),
    .flip    (load_last),
    .rd_en   (en),
    .rd_addr (stored_addr),
    .rd_data (stored_data),
    .wr_en   (load),
    .wr_addr (tag_done.index),
    .wr_data (sum_sat)
  );

  mcacc_mac u_mac (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .tag_in  (tag_rd),
    .op_a    (stored_data),
    .op_b    (incoming_data),
    .tag_out (tag_done),
    .sum_sat (sum_sat)
  );

  // Output register: one finished element per beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.result_value <= sum_sat;
      result.result_index <= tag_done.index;
      result.last_element <= (tag_done.index == mcacc_pkg::IDX_LAST);
    end
  end

endmodule
